// ===== hdl/cssd_pkg.sv =====
// Shared types and constants of the cross stencil star detector.
package cssd_pkg;

  // Width of each configuration register
  localparam int CFG_W = 11;
  // Width of the configuration register index
  localparam int CFG_IDX_W = 2;
  // Width of the reported row and column indexes
  localparam int IDX_W = 10;

  // Register reset values
  localparam logic [CFG_W-1:0] FRAME_ROWS_RST = CFG_W'(20);
  localparam logic [CFG_W-1:0] FRAME_COLS_RST = CFG_W'(20);
  localparam logic [CFG_W-1:0] STAR_THRESHOLD_RST = CFG_W'(30);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_ROWS     = 2'd0,
    REG_FRAME_COLS     = 2'd1,
    REG_STAR_THRESHOLD = 2'd2
  } reg_idx_t;

  // Raster position facts of one accepted pixel
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             has_first;   // classifies the pixel one row above
    logic             has_second;  // last row: emits its own blank result
    logic             inner;       // pixel above lies off the frame border
    logic             done;        // last column of the row
  } tag_t;

  // Classified item handed to the result stage
  typedef struct packed {
    logic             star;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             has_first;
    logic             has_second;
    logic             done;
  } cls_t;

endpackage

// ===== hdl/cssd_if.sv =====
// Channel interfaces of the cross stencil star detector: pixels, results, config.
interface cssd_pix_if #(
  parameter int PIXEL_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface cssd_res_if ();
  logic                         valid;
  logic                         ready;
  logic                         is_star;
  logic [cssd_pkg::IDX_W-1:0]   out_row;
  logic [cssd_pkg::IDX_W-1:0]   out_col;
  logic                         run_last;
  logic                         frame_done;

  modport source (output valid, output is_star, output out_row, output out_col,
                  output run_last, output frame_done, input ready);
  modport sink (input valid, input is_star, input out_row, input out_col,
                input run_last, input frame_done, output ready);
endinterface

interface cssd_cfg_if ();
  logic                           valid;
  logic                           ready;
  logic [cssd_pkg::CFG_IDX_W-1:0] index;
  logic [cssd_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/cross_stencil_star_detect.sv =====
// Top level of the cross stencil star detector: config, raster counters, line buffers.
//
// Pixels arrive on the pixels channel in raster order, one per transfer. Each
// result on the results channel marks one pixel as star or blank with its row
// and column. A pixel of row r classifies the pixel of row r-1 in its column;
// a pixel of the last row also sends its own blank result after that one.
// Pixels of the first row send nothing unless the frame has a single row.
// run_last marks the final result of a pixel, frame_done the frame's last.
// The cfg channel writes frame_rows, frame_cols and star_threshold; it is
// always ready, and every write to a known register restarts the frame.
// A result passes the input stage (with the line buffer read) and then the
// result register before it is valid. Throughput: one pixel per cycle while
// results are taken; a last-row pixel of a frame taller than one row holds the
// single result port for both of its results.
// Both line buffers sit in one RAM, read one column ahead of the pixel.
// Reset clears the counters and pipeline and loads the register defaults;
// buffer contents are not cleared. When the receiver stalls, the result
// register holds and the input stage backs up after one more pixel.
module cross_stencil_star_detect #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  parameter int PIXEL_BITS = 8
) (
  input logic        clk,
  input logic        rst,
  cssd_pix_if.sink   pixels,
  cssd_res_if.source results,
  cssd_cfg_if.sink   cfg
);

  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int RL_W = ($clog2(MAX_ROWS + 1) > cssd_pkg::CFG_W) ?
                        $clog2(MAX_ROWS + 1) : cssd_pkg::CFG_W;
  localparam int CL_W = ($clog2(MAX_COLS + 1) > cssd_pkg::CFG_W) ?
                        $clog2(MAX_COLS + 1) : cssd_pkg::CFG_W;

  logic [cssd_pkg::CFG_W-1:0] frame_rows;
  logic [cssd_pkg::CFG_W-1:0] frame_cols;
  logic [cssd_pkg::CFG_W-1:0] star_threshold;
  logic                       cfg_restart;

  logic [ROW_W-1:0]  row_count;
  logic [ADDR_W-1:0] col_count;
  logic [ROW_W-1:0]  row_count_next;
  logic [ADDR_W-1:0] col_count_next;
  logic [RL_W-1:0]   rows_lim;
  logic [CL_W-1:0]   cols_lim;
  logic              last_row;
  logic              last_col;
  logic [ADDR_W-1:0] next_addr;

  logic                    accept;
  cssd_pkg::tag_t          tag;
  logic                    s1_full;
  logic                    s1_adv;
  cssd_pkg::cls_t          cls;
  logic                    res_free;
  logic                    needs_out;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [2*PIXEL_BITS-1:0] wr_data;
  logic [2*PIXEL_BITS-1:0] rd_data;

  // Write configuration registers; known registers restart the frame
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows     <= cssd_pkg::FRAME_ROWS_RST;
      frame_cols     <= cssd_pkg::FRAME_COLS_RST;
      star_threshold <= cssd_pkg::STAR_THRESHOLD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        cssd_pkg::REG_FRAME_ROWS:     frame_rows <= cfg.data;
        cssd_pkg::REG_FRAME_COLS:     frame_cols <= cfg.data;
        cssd_pkg::REG_STAR_THRESHOLD: star_threshold <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_restart = cfg.valid && (cfg.index == cssd_pkg::REG_FRAME_ROWS ||
                                     cfg.index == cssd_pkg::REG_FRAME_COLS ||
                                     cfg.index == cssd_pkg::REG_STAR_THRESHOLD);

  // Clamp frame size: zero acts as one, oversize as the maximum
  always_comb begin
    if (frame_rows == '0) begin
      rows_lim = RL_W'(1);
    end else if (RL_W'(frame_rows) > RL_W'(MAX_ROWS)) begin
      rows_lim = RL_W'(MAX_ROWS);
    end else begin
      rows_lim = RL_W'(frame_rows);
    end
    if (frame_cols == '0) begin
      cols_lim = CL_W'(1);
    end else if (CL_W'(frame_cols) > CL_W'(MAX_COLS)) begin
      cols_lim = CL_W'(MAX_COLS);
    end else begin
      cols_lim = CL_W'(frame_cols);
    end
  end

  assign last_row = (RL_W'(row_count) == rows_lim - RL_W'(1));
  assign last_col = (CL_W'(col_count) == cols_lim - CL_W'(1));

  // Advance the raster position on each pixel transfer
  always_comb begin
    row_count_next = row_count;
    col_count_next = col_count;
    if (cfg_restart) begin
      row_count_next = '0;
      col_count_next = '0;
    end else if (accept) begin
      if (last_col) begin
        col_count_next = '0;
        row_count_next = last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count_next = col_count + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // Read the line buffer entry of the column that follows in raster order
  assign next_addr = last_col ? '0 : col_count + ADDR_W'(1);

  // Tag the pixel with its raster facts
  always_comb begin
    tag.row        = cssd_pkg::IDX_W'(row_count);
    tag.col        = cssd_pkg::IDX_W'(col_count);
    tag.has_first  = (row_count != '0);
    tag.has_second = last_row;
    tag.inner      = (row_count >= ROW_W'(2)) && (col_count != '0) && !last_col;
    tag.done       = last_col;
  end

  // Handshake between stages
  assign needs_out    = cls.has_first || cls.has_second;
  assign s1_adv       = s1_full && (!needs_out || res_free);
  assign pixels.ready = !s1_full || s1_adv;
  assign accept       = pixels.valid && pixels.ready;

  cssd_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_COLS)
  ) u_lines (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (next_addr),
    .rd_data (rd_data)
  );

  cssd_stencil #(
    .PIXEL_BITS (PIXEL_BITS),
    .ADDR_W     (ADDR_W)
  ) u_stencil (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .pixel     (pixels.pixel),
    .tag       (tag),
    .addr      (col_count),
    .rd_data   (rd_data),
    .threshold (star_threshold),
    .advance   (s1_adv),
    .full      (s1_full),
    .cls       (cls),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  cssd_result u_result (
    .clk  (clk),
    .rst  (rst),
    .load (s1_adv && needs_out),
    .cls  (cls),
    .free (res_free),
    .res  (results)
  );

  // The frame's final result is always the last of its pixel and blank
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.frame_done |-> results.run_last && !results.is_star)
    else $error("frame_done on a result that is not a blank final result");

  // A transfer that is not the pixel's last leaves the second result waiting
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && !results.run_last |=> results.valid)
    else $error("second result of a pixel missing");

  // The input stage never takes a pixel while it holds one that cannot leave
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_full && !s1_adv |=> s1_full && $stable(cls))
    else $error("input stage overwritten while stalled");

endmodule

// ===== hdl/cssd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module cssd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/cssd_stencil.sv =====
// Input stage: pixel register, cross window registers, sum and threshold compare.
module cssd_stencil #(
  parameter int PIXEL_BITS = 8,
  parameter int ADDR_W = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [PIXEL_BITS-1:0]     pixel,
  input  cssd_pkg::tag_t            tag,
  input  logic [ADDR_W-1:0]         addr,
  input  logic [2*PIXEL_BITS-1:0]   rd_data,
  input  logic [cssd_pkg::CFG_W-1:0] threshold,
  input  logic                      advance,
  output logic                      full,
  output cssd_pkg::cls_t            cls,
  output logic                      wr_en,
  output logic [ADDR_W-1:0]         wr_addr,
  output logic [2*PIXEL_BITS-1:0]   wr_data
);

  localparam int SUM_W = PIXEL_BITS + 3;
  localparam int CMP_W = (SUM_W > cssd_pkg::CFG_W) ? SUM_W : cssd_pkg::CFG_W;

  logic                  full_next;
  logic [PIXEL_BITS-1:0] px_q;
  cssd_pkg::tag_t        tag_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [PIXEL_BITS-1:0] cur_prev;   // row above, same column
  logic [PIXEL_BITS-1:0] cur_prev2;  // two rows above, same column
  logic [PIXEL_BITS-1:0] lft;        // row above, column to the left
  logic [PIXEL_BITS-1:0] rgt;        // row above, column to the right
  logic [SUM_W-1:0]      sum;

  // Track occupancy of the stage
  always_comb begin
    full_next = full;
    if (load) begin
      full_next = 1'b1;
    end else if (advance) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  // Capture pixel and shift the window; read data holds this column's entry
  always_ff @(posedge clk) begin
    if (load) begin
      px_q      <= pixel;
      tag_q     <= tag;
      addr_q    <= addr;
      cur_prev  <= rd_data[PIXEL_BITS-1:0];
      cur_prev2 <= rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
      lft       <= cur_prev;
    end
  end

  // Read data now holds the entry of the next column
  assign rgt = rd_data[PIXEL_BITS-1:0];

  // Cross sum of center, up, down, left and right
  assign sum = SUM_W'(cur_prev) + SUM_W'(cur_prev2) + SUM_W'(px_q)
             + SUM_W'(lft) + SUM_W'(rgt);

  always_comb begin
    cls.star       = tag_q.inner && (CMP_W'(sum) > CMP_W'(threshold));
    cls.row        = tag_q.row;
    cls.col        = tag_q.col;
    cls.has_first  = tag_q.has_first;
    cls.has_second = tag_q.has_second;
    cls.done       = tag_q.done;
  end

  // Shift the column down the line buffers as the pixel leaves
  assign wr_en   = advance;
  assign wr_addr = addr_q;
  assign wr_data = {cur_prev, px_q};

endmodule

// ===== hdl/cssd_result.sv =====
// Output stage: holds one classified pixel and sends its one or two results.
module cssd_result (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cssd_pkg::cls_t   cls,
  output logic             free,
  cssd_res_if.source       res
);

  logic                       first_pend;
  logic                       second_pend;
  logic                       first_pend_next;
  logic                       second_pend_next;
  logic                       star_q;
  logic [cssd_pkg::IDX_W-1:0] row_q;
  logic [cssd_pkg::IDX_W-1:0] col_q;
  logic                       done_q;
  logic                       xfer;

  assign xfer = res.valid && res.ready;
  // Stage takes a new item when empty or when its final result leaves now
  assign free = !(first_pend || second_pend) || (res.ready && !(first_pend && second_pend));

  // Sequence pending results
  always_comb begin
    first_pend_next  = first_pend;
    second_pend_next = second_pend;
    if (xfer) begin
      if (first_pend) begin
        first_pend_next = 1'b0;
      end else begin
        second_pend_next = 1'b0;
      end
    end
    if (load) begin
      first_pend_next  = cls.has_first;
      second_pend_next = cls.has_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pend  <= 1'b0;
      second_pend <= 1'b0;
    end else begin
      first_pend  <= first_pend_next;
      second_pend <= second_pend_next;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (load) begin
      star_q <= cls.star;
      row_q  <= cls.row;
      col_q  <= cls.col;
      done_q <= cls.done;
    end
  end

  // First result classifies the row above, second is the blank last-row pixel
  always_comb begin
    res.valid = first_pend || second_pend;
    res.out_col = col_q;
    if (first_pend) begin
      res.is_star    = star_q;
      res.out_row    = row_q - cssd_pkg::IDX_W'(1);
      res.run_last   = !second_pend;
      res.frame_done = 1'b0;
    end else begin
      res.is_star    = 1'b0;
      res.out_row    = row_q;
      res.run_last   = 1'b1;
      res.frame_done = done_q;
    end
  end

endmodule

// ===== dv/cssd_star_checker.sv =====
`timescale 1ns / 100ps
// Checker of the cross stencil star detector: predicts every star mark and compares results.
module cssd_star_checker #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  cssd_pix_if  pixels,
  cssd_res_if  results,
  cssd_cfg_if  cfg,
  output int   mismatches,
  output int   marks_pending
);

  typedef struct packed {
    logic                       star;
    logic [cssd_pkg::IDX_W-1:0] row;
    logic [cssd_pkg::IDX_W-1:0] col;
    logic                       last;
    logic                       done;
  } star_mark_t;

  logic [cssd_pkg::CFG_W-1:0] rows_reg;
  logic [cssd_pkg::CFG_W-1:0] cols_reg;
  logic [cssd_pkg::CFG_W-1:0] threshold_reg;
  logic [PIXEL_BITS-1:0]      row_above [MAX_COLS];
  logic [PIXEL_BITS-1:0]      row_two_above [MAX_COLS];
  int unsigned                row_pos;
  int unsigned                col_pos;
  star_mark_t                 expected_marks [$];

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // Zero acts as one, anything past the buffer size as the buffer size
  function automatic int unsigned effective_size(logic [cssd_pkg::CFG_W-1:0] v,
                                                 int unsigned limit);
    if (v == '0) return 1;
    return (32'(v) > limit) ? limit : 32'(v);
  endfunction

  // Any write to a known register restarts the frame; buffers are kept
  task automatic apply_write(logic [cssd_pkg::CFG_IDX_W-1:0] idx,
                             logic [cssd_pkg::CFG_W-1:0] value);
    case (idx)
      cssd_pkg::REG_FRAME_ROWS:     rows_reg = value;
      cssd_pkg::REG_FRAME_COLS:     cols_reg = value;
      cssd_pkg::REG_STAR_THRESHOLD: threshold_reg = value;
      default:                      return;
    endcase
    row_pos = 0;
    col_pos = 0;
  endtask

  // Classify the pixel one row up and, on the last row, this pixel itself
  task automatic classify_pixel(logic [PIXEL_BITS-1:0] px);
    int unsigned nrows;
    int unsigned ncols;
    int unsigned r;
    int unsigned c;
    int unsigned cross_sum;
    logic        bottom;
    star_mark_t  mark;
    nrows = effective_size(rows_reg, MAX_ROWS);
    ncols = effective_size(cols_reg, MAX_COLS);
    if (row_pos >= nrows || col_pos >= ncols) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    bottom = (r == nrows - 1);
    if (r >= 1) begin
      mark.star = 1'b0;
      if (r - 1 != 0 && c != 0 && c != ncols - 1) begin
        // left neighbour already moved down into the older line
        cross_sum = 32'(row_above[c]) + 32'(row_two_above[c]) + 32'(px)
                  + 32'(row_two_above[c - 1]) + 32'(row_above[c + 1]);
        mark.star = (cross_sum > threshold_reg);
      end
      mark.row  = cssd_pkg::IDX_W'(r - 1);
      mark.col  = cssd_pkg::IDX_W'(c);
      mark.last = !bottom;
      mark.done = 1'b0;
      expected_marks = {expected_marks, mark};
    end
    if (bottom) begin
      mark.star = 1'b0;
      mark.row  = cssd_pkg::IDX_W'(r);
      mark.col  = cssd_pkg::IDX_W'(c);
      mark.last = 1'b1;
      mark.done = (c == ncols - 1);
      expected_marks = {expected_marks, mark};
    end
    row_two_above[c] = row_above[c];
    row_above[c] = px;
    // advance the raster position, wrapping into the next frame
    if (c + 1 >= ncols) begin
      col_pos = 0;
      row_pos = (r + 1 >= nrows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_mark();
    star_mark_t want;
    if (expected_marks.size() == 0) begin
      flag_mismatch($sformatf("result at (%0d,%0d) with none expected",
                              results.out_row, results.out_col));
      return;
    end
    want = expected_marks.pop_front();
    if (results.is_star !== want.star)
      flag_mismatch($sformatf("is_star at (%0d,%0d): got %b want %b",
                              want.row, want.col, results.is_star, want.star));
    if (results.out_row !== want.row)
      flag_mismatch($sformatf("out_row: got %0d want %0d", results.out_row, want.row));
    if (results.out_col !== want.col)
      flag_mismatch($sformatf("out_col: got %0d want %0d", results.out_col, want.col));
    if (results.run_last !== want.last)
      flag_mismatch($sformatf("run_last at (%0d,%0d): got %b want %b",
                              want.row, want.col, results.run_last, want.last));
    if (results.frame_done !== want.done)
      flag_mismatch($sformatf("frame_done at (%0d,%0d): got %b want %b",
                              want.row, want.col, results.frame_done, want.done));
  endtask

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      rows_reg = cssd_pkg::FRAME_ROWS_RST;
      cols_reg = cssd_pkg::FRAME_COLS_RST;
      threshold_reg = cssd_pkg::STAR_THRESHOLD_RST;
      row_pos = 0;
      col_pos = 0;
      expected_marks.delete();
      mismatches = 0;
    end else begin
      if (results.valid && results.ready) check_mark();
      if (cfg.valid && cfg.ready) apply_write(cfg.index, cfg.data);
      if (pixels.valid && pixels.ready) classify_pixel(pixels.pixel);
    end
    marks_pending = expected_marks.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the star detector testbench: clock, reset, stimulus, result stalls and verdict.
module testbench;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int PIXEL_BITS = 8;
  localparam int RANDOM_PIXELS = 470;
  localparam int LONG_HOLD = 60;
  localparam int DRAIN_CYCLES = 6;
  // index past the register list; a write there changes nothing
  localparam logic [cssd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STYLE_UNIFORM = 0;
  localparam int STYLE_EXTREME = 1;
  localparam int STYLE_DIM = 2;

  logic clk;
  logic rst;
  int   mismatches;
  int   marks_pending;
  bit   tx_gaps;
  bit   rx_stalls;
  bit   hold_request;
  int   random_sent;

  cssd_pix_if #(.PIXEL_BITS(PIXEL_BITS)) pix_ch ();
  cssd_res_if res_ch ();
  cssd_cfg_if cfg_ch ();

  cross_stencil_star_detect #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS),
    .PIXEL_BITS(PIXEL_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .pixels(pix_ch),
    .results(res_ch),
    .cfg(cfg_ch)
  );

  cssd_star_checker #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS),
    .PIXEL_BITS(PIXEL_BITS)
  ) chk (
    .clk(clk),
    .rst(rst),
    .pixels(pix_ch),
    .results(res_ch),
    .cfg(cfg_ch),
    .mismatches(mismatches),
    .marks_pending(marks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("testbench failed");
    $finish;
  end

  // Idle cycles before one item: none when disabled, else a random gap that is often none
  function automatic int draw_gap(bit enabled);
    if (!enabled || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 16);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] draw_pixel(int style);
    case (style)
      STYLE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      STYLE_DIM:     return PIXEL_BITS'($urandom_range(0, 15));
      default:       return PIXEL_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [cssd_pkg::CFG_W-1:0] draw_threshold(int style);
    case (style)
      STYLE_EXTREME: return cssd_pkg::CFG_W'($urandom_range(0, 1300));
      STYLE_DIM:     return cssd_pkg::CFG_W'($urandom_range(0, 80));
      default:       return ($urandom_range(0, 3) != 0) ?
                            cssd_pkg::CFG_W'($urandom_range(400, 900)) :
                            cssd_pkg::CFG_W'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic logic [cssd_pkg::CFG_W-1:0] draw_size();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return cssd_pkg::CFG_W'($urandom_range(1025, 2047));
      2, 3, 4: return cssd_pkg::CFG_W'($urandom_range(7, 16));
      default: return cssd_pkg::CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  // Leaves valid high; the caller drops it once the writes are done
  task automatic write_register(logic [cssd_pkg::CFG_IDX_W-1:0] idx,
                                logic [cssd_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic configure(logic [cssd_pkg::CFG_W-1:0] rows,
                           logic [cssd_pkg::CFG_W-1:0] cols,
                           logic [cssd_pkg::CFG_W-1:0] threshold);
    write_register(cssd_pkg::REG_FRAME_ROWS, rows);
    write_register(cssd_pkg::REG_FRAME_COLS, cols);
    write_register(cssd_pkg::REG_STAR_THRESHOLD, threshold);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Leaves valid high so back-to-back pixels stream without a bubble
  task automatic send_pixel(logic [PIXEL_BITS-1:0] px);
    int gap;
    gap = draw_gap(tx_gaps);
    @(negedge clk);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // Hold until every predicted mark is out, then let the pipe empty
  task automatic wait_quiet();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (marks_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic stream_pixels(int count, int style, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        // drain mid-frame, then poke the unused index: the frame must go on
        wait_quiet();
        write_register(REG_UNUSED, cssd_pkg::CFG_W'($urandom_range(0, 2047)));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
      end
      send_pixel(draw_pixel(style));
    end
  endtask

  // Result side: stall at random, or hold off for a long stretch on request
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = draw_gap(rx_stalls);
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    int style;
    int count;
    int pause_at;
    bit first_phase;
    rst = 1'b1;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = cssd_pkg::REG_FRAME_ROWS;
    cfg_ch.data = '0;
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    hold_request = 1'b0;
    random_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: two rows and a bit of a 20x20 frame
    stream_pixels(42, STYLE_UNIFORM, -1);
    wait_quiet();

    // 3x3 of full-scale pixels: sum 1275 just over the threshold
    configure(11'd3, 11'd3, 11'd1274);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF);
    // next frame after the wrap: centre one lower makes the sum equal, no star
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd254 : 8'd255);
    wait_quiet();

    // One-row frame: every pixel sends only its own blank mark
    configure(11'd1, 11'd4, 11'd30);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h5A);
    send_pixel(8'hA5);
    wait_quiet();

    // Zero sizes act as a 1x1 frame
    configure(11'd0, 11'd0, 11'd0);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    wait_quiet();

    // Random frames; the first one holds off the results and pauses
    first_phase = 1'b1;
    while (random_sent < RANDOM_PIXELS) begin
      style = $urandom_range(0, 2);
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : $urandom_range(20, 120);
      pause_at = (first_phase || $urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1;
      configure(draw_size(), draw_size(), draw_threshold(style));
      tx_gaps = ($urandom_range(0, 2) != 0);
      rx_stalls = ($urandom_range(0, 2) != 0);
      if (first_phase || $urandom_range(0, 5) == 0) begin
        tx_gaps = 1'b0;
        hold_request = 1'b1;
      end
      stream_pixels(count, style, pause_at);
      random_sent += count;
      first_phase = 1'b0;
      wait_quiet();
    end

    if (mismatches == 0 && marks_pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cssd_pkg.sv
hdl/cssd_if.sv
hdl/cssd_ram.sv
hdl/cssd_stencil.sv
hdl/cssd_result.sv
hdl/cross_stencil_star_detect.sv
dv/cssd_star_checker.sv
dv/testbench.sv
